/* rtl/cbl_pkg.sv */
package cbl_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_COEF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TWO = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef enum logic [1:0] {
    COEF_A1,
    COEF_A4,
    COEF_A5
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPND_D1,
    OPND_D2,
    OPND_S
  } opnd_sel_e;

  // What to do with a finished product when it leaves the multiplier pipeline.
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_T1,
    TAG_T2,
    TAG_Y
  } tag_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_DONE
  } jump_e;

  typedef struct packed {
    logic      iss;
    coef_sel_e coef;
    opnd_sel_e opnd;
    logic      hi;
    tag_e      tag;
    logic      fetch;
    logic      ty;
    logic      scalc;
    logic      outp;
    jump_e     jmp;
  } ucode_t;

  localparam int PC_W   = 4;
  localparam int UC_LEN = 14;

  localparam logic [PC_W-1:0] LOOP_PC = 4'd7;

  // Steps 0 to 6 form the prologue, 7 to 12 the section loop, 13 the output step.
  localparam ucode_t UCODE [UC_LEN] = '{
    '{1'b1, COEF_A4, OPND_D1, 1'b1, TAG_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A4, OPND_D1, 1'b0, TAG_T1,   1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A5, OPND_D2, 1'b1, TAG_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A5, OPND_D2, 1'b0, TAG_T2,   1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b0, COEF_A1, OPND_D1, 1'b0, TAG_NONE, 1'b1, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A4, OPND_D1, 1'b1, TAG_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A4, OPND_D1, 1'b0, TAG_T1,   1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A5, OPND_D2, 1'b1, TAG_NONE, 1'b0, 1'b1, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A5, OPND_D2, 1'b0, TAG_T2,   1'b0, 1'b0, 1'b1, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A1, OPND_S,  1'b1, TAG_NONE, 1'b1, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A1, OPND_S,  1'b0, TAG_Y,    1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A4, OPND_D1, 1'b1, TAG_NONE, 1'b0, 1'b0, 1'b0, 1'b0, JMP_NEXT},
    '{1'b1, COEF_A4, OPND_D1, 1'b0, TAG_T1,   1'b0, 1'b0, 1'b0, 1'b0, JMP_LOOP},
    '{1'b0, COEF_A1, OPND_D1, 1'b0, TAG_NONE, 1'b0, 1'b0, 1'b0, 1'b1, JMP_DONE}
  };

endpackage

/* rtl/cbl_if.sv */
interface cbl_smp_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cbl_smp_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface cbl_cfg_if ();
  import cbl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/cascaded_butterworth_lowpass.sv */
// Cascaded second-order Butterworth lowpass, SECTIONS identical direct form II sections.
// Samples arrive on smp_in_i and filtered samples leave on smp_out_o, one result beat
// for every input beat. Coefficients (gain, first and second feedback, Q3.28) are
// written on cfg_i, which is always ready; write them only while the filter is idle.
// An input beat is taken only while the sequencer is idle. A microcode program then
// drives one shared 32x28 multiplier; each product issues twice, high half then low, six
// issues per section, and the section loop overlaps the next section's feedback products
// with the current section's gain product.
// The result is written on the output step, which also returns the sequencer to idle,
// so a new input beat can be taken only once the previous sample's run is done.
// The result sits in an output register; the next sample may be taken while it waits.
// If the previous result is still not taken when the next one is done, the sequencer
// holds on its output step until the receiver takes it.
// Reset clears coefficients, all section delay values and the output valid.
module cascaded_butterworth_lowpass #(
  parameter int SECTIONS    = 7,
  parameter int SAMPLE_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cbl_cfg_if.sink        cfg_i,
  cbl_smp_in_if.sink     smp_in_i,
  cbl_smp_out_if.source  smp_out_o
);
  import cbl_pkg::*;

  localparam int IW     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int FW     = $clog2(SECTIONS + 2);
  localparam int QSHIFT = 33 - SAMPLE_BITS;

  localparam logic signed [39:0] OUT_MAX = 40'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [39:0] OUT_MIN = -OUT_MAX - 40'sd1;
  localparam logic signed [49:0] SAT_HI  = 50'sd549755813887;
  localparam logic signed [49:0] SAT_LO  = -50'sd549755813888;

  function automatic logic signed [39:0] sat40(input logic signed [49:0] v);
    logic signed [39:0] r;
    priority if (v > SAT_HI) begin
      r = SAT_HI[39:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[39:0];
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  state_e            st_q, st_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [IW-1:0]     sc_q, sc_d;
  logic [FW-1:0]     fi_q, fi_d;
  ucode_t            uc, uc_act;
  logic              load_in;

  logic signed [31:0] gain_q, fb1_q, fb2_q;
  logic signed [39:0] d1_q [SECTIONS];
  logic signed [39:0] d2_q [SECTIONS];
  logic signed [39:0] rd1, rd2;

  logic signed [39:0] fd1_q, fd2_q, sd1_q, sd2_q;
  logic signed [39:0] y_q, t_q;
  logic signed [42:0] s_q;
  logic signed [48:0] facc_q;

  logic signed [31:0] mul_a;
  logic signed [42:0] mul_v;
  logic signed [27:0] mul_b;
  logic signed [59:0] prod_d, prod_q;
  logic signed [75:0] acc_q, psum;
  logic signed [47:0] p_q;
  logic               m_vld_q, m_hi_q;
  tag_e               m_tag_q, p_tag_q;

  logic signed [39:0]            ysh;
  logic signed [SAMPLE_BITS-1:0] out_d, out_q;
  logic                          out_vld_q;

  assign uc = UCODE[pc_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      pc_q <= '0;
      sc_q <= '0;
      fi_q <= '0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
      sc_q <= sc_d;
      fi_q <= fi_d;
    end
  end

  always_comb begin
    st_d    = st_q;
    pc_d    = pc_q;
    sc_d    = sc_q;
    fi_d    = fi_q;
    uc_act  = '0;
    load_in = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (smp_in_i.valid) begin
          load_in = 1'b1;
          st_d    = ST_RUN;
          pc_d    = '0;
          fi_d    = fi_q + FW'(1);
        end
      end
      ST_RUN: begin
        if (!(uc.outp && out_vld_q && !smp_out_o.ready)) begin
          uc_act = uc;
          if (uc.fetch) begin
            fi_d = fi_q + FW'(1);
          end
          unique case (uc.jmp)
            JMP_NEXT: pc_d = pc_q + PC_W'(1);
            JMP_LOOP: begin
              if (sc_q == IW'(SECTIONS - 1)) begin
                pc_d = pc_q + PC_W'(1);
              end else begin
                sc_d = sc_q + IW'(1);
                pc_d = LOOP_PC;
              end
            end
            JMP_DONE: begin
              st_d = ST_IDLE;
              pc_d = '0;
              sc_d = '0;
              fi_d = '0;
            end
            default: pc_d = pc_q;
          endcase
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign rd1 = (fi_q < FW'(SECTIONS)) ? d1_q[fi_q[IW-1:0]] : '0;
  assign rd2 = (fi_q < FW'(SECTIONS)) ? d2_q[fi_q[IW-1:0]] : '0;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      fb1_q  <= '0;
      fb2_q  <= '0;
      d1_q   <= '{default: '0};
      d2_q   <= '{default: '0};
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_GAIN_COEF:    gain_q <= signed'(cfg_i.data);
          CFG_FEEDBACK_ONE: fb1_q  <= signed'(cfg_i.data);
          CFG_FEEDBACK_TWO: fb2_q  <= signed'(cfg_i.data);
          default: ;
        endcase
      end
      if (uc_act.scalc) begin
        d1_q[sc_q] <= t_q;
        d2_q[sc_q] <= sd1_q;
      end
    end
  end

  always_comb begin
    unique case (uc_act.coef)
      COEF_A1: mul_a = gain_q;
      COEF_A4: mul_a = fb1_q;
      COEF_A5: mul_a = fb2_q;
      default: mul_a = '0;
    endcase
    unique case (uc_act.opnd)
      OPND_D1: mul_v = {{3{fd1_q[39]}}, fd1_q};
      OPND_D2: mul_v = {{3{fd2_q[39]}}, fd2_q};
      OPND_S:  mul_v = s_q;
      default: mul_v = '0;
    endcase
    mul_b = uc_act.hi ? {mul_v[42], mul_v[42:16]} : {12'h000, mul_v[15:0]};
  end

  assign prod_d = mul_a * mul_b;
  assign psum   = acc_q + {{16{prod_q[59]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      m_hi_q  <= 1'b0;
      m_tag_q <= TAG_NONE;
      p_tag_q <= TAG_NONE;
    end else begin
      m_vld_q <= uc_act.iss;
      m_hi_q  <= uc_act.hi;
      m_tag_q <= uc_act.iss ? uc_act.tag : TAG_NONE;
      p_tag_q <= (m_vld_q && !m_hi_q) ? m_tag_q : TAG_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc_act.iss) begin
      prod_q <= prod_d;
    end
    if (m_vld_q && m_hi_q) begin
      acc_q <= {prod_q, 16'h0000};
    end
    if (m_vld_q && !m_hi_q) begin
      p_q <= psum[75:28];
    end
    unique case (p_tag_q)
      TAG_T1:  facc_q <= -{p_q[47], p_q};
      TAG_T2:  facc_q <= facc_q - {p_q[47], p_q};
      TAG_Y:   y_q <= sat40({{2{p_q[47]}}, p_q});
      default: ;
    endcase
    if (load_in) begin
      y_q <= 40'(smp_in_i.sample_in) << QSHIFT;
    end
    if (uc_act.ty) begin
      t_q <= sat40({{10{y_q[39]}}, y_q} + {facc_q[48], facc_q});
    end
    if (uc_act.scalc) begin
      s_q <= {{3{t_q[39]}}, t_q} + {{2{sd1_q[39]}}, sd1_q, 1'b0} + {{3{sd2_q[39]}}, sd2_q};
    end
    if (load_in || uc_act.fetch) begin
      sd1_q <= fd1_q;
      sd2_q <= fd2_q;
      fd1_q <= rd1;
      fd2_q <= rd2;
    end
    if (uc_act.outp) begin
      out_q <= out_d;
    end
  end

  assign ysh = y_q >>> QSHIFT;

  always_comb begin
    priority if (ysh > OUT_MAX) begin
      out_d = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (ysh < OUT_MIN) begin
      out_d = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      out_d = ysh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (uc_act.outp) begin
      out_vld_q <= 1'b1;
    end else if (smp_out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign smp_in_i.ready       = (st_q == ST_IDLE);
  assign smp_out_o.valid      = out_vld_q;
  assign smp_out_o.sample_out = out_q;

endmodule

/* rtl/cbl_checker.sv */
module cbl_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_data_i
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its sample.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result sample changed while stalled");

  // Only one sample is in the filter at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again right after a sample beat");

  // A new result only appears at the end of a filter run.
  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a filter run");

endmodule

bind cascaded_butterworth_lowpass cbl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_in_i.valid),
  .in_ready_i  (smp_in_i.ready),
  .out_valid_i (smp_out_o.valid),
  .out_ready_i (smp_out_o.ready),
  .out_data_i  (smp_out_o.sample_out)
);
